@@ rtl/chkv_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chkv_pkg
// Shared types and constants for the chained hash key-value store.
// ----------------------------------------------------------------------------
package chkv_pkg;
    localparam int Buckets     = 16;
    localparam int PoolEntries = 64;
    localparam int KeyChars    = 19;

    localparam int BucketW = (Buckets > 1) ? $clog2(Buckets) : 1;
    localparam int EntryW  = 7;
    localparam int CountW  = 5;
    localparam int KeyMemD = PoolEntries * KeyChars;
    localparam int KeyMemW = $clog2(KeyMemD);
    localparam int FifoD   = 2;

    localparam logic [EntryW-1:0] NullLink  = 7'h7F;
    localparam logic [31:0]       MissValue = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        ACT_INSERT = 2'd0,
        ACT_SEARCH = 2'd1,
        ACT_DELETE = 2'd2,
        ACT_OTHER  = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NOTFOUND = 2'd1,
        ST_FULL     = 2'd2,
        ST_TOOLONG  = 2'd3
    } t_status;

    // terminator command passed from front to back
    typedef struct packed {
        t_action             action;
        logic [BucketW-1:0]  bucket;
        logic [CountW-1:0]   count;
        logic                overflow;
        logic signed [31:0]  value;
    } t_cmd;

    typedef enum logic [3:0] {
        S_IDLE, S_CLEAR, S_INS_KEY, S_INS_FIN, S_HEAD, S_ENTRY, S_ENTRY_W,
        S_CMP, S_CMP_W, S_NEXT, S_HIT, S_DONE
    } t_state;
endpackage

@@ rtl/chkv_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chkv_ram
// Generic single-port write, single-port read RAM with registered read.
// ----------------------------------------------------------------------------
module chkv_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

@@ rtl/chkv_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chkv_front
// Takes key characters, keeps the running hash and key, and hands each
// terminator to the back end through a small command queue.
// ----------------------------------------------------------------------------
module chkv_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    output logic                          o_busy,
    input  logic [1:0]                    i_action,
    input  logic [7:0]                    i_key_char,
    input  logic signed [31:0]            i_value_in,
    // key buffer write to the back end's key RAM
    output logic                          o_kb_we,
    output logic [chkv_pkg::CountW-1:0]   o_kb_addr,
    output logic [7:0]                    o_kb_data,
    // command queue
    output logic                          o_cmd_valid,
    output chkv_pkg::t_cmd                o_cmd,
    input  logic                          i_cmd_pop,
    input  logic                          i_back_idle
);
    import chkv_pkg::*;

    logic [31:0]       r_hash;
    logic [CountW-1:0] r_count;
    logic              r_ovf;
    t_cmd              r_q;
    logic              r_qv;
    logic              accept, term;

    // the key buffer is shared with the back end, so a new key waits until
    // the queued command has been fully consumed
    assign o_busy = r_qv || !i_back_idle;
    assign accept = i_start && !o_busy;
    assign term   = (i_key_char == 8'd0);

    assign o_kb_we   = accept && !term && (r_count < CountW'(KeyChars));
    assign o_kb_addr = r_count;
    assign o_kb_data = i_key_char;
    assign o_cmd_valid = r_qv;
    assign o_cmd       = r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash  <= '0;
            r_count <= '0;
            r_ovf   <= 1'b0;
            r_qv    <= 1'b0;
        end else begin
            if (i_cmd_pop) begin
                r_qv <= 1'b0;
            end
            if (accept) begin
                if (term) begin
                    r_q.action   <= t_action'(i_action);
                    r_q.bucket   <= BucketW'(r_hash % Buckets);
                    r_q.count    <= r_count;
                    r_q.overflow <= r_ovf;
                    r_q.value    <= i_value_in;
                    r_qv    <= 1'b1;
                    r_hash  <= '0;
                    r_count <= '0;
                    r_ovf   <= 1'b0;
                end else begin
                    r_hash <= (r_hash << 5) - r_hash + {24'd0, i_key_char};
                    if (r_count < CountW'(KeyChars)) begin
                        r_count <= r_count + 1'b1;
                    end else begin
                        r_ovf <= 1'b1;
                    end
                end
            end
        end
    end
endmodule

@@ rtl/chkv_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chkv_back
// Carries out insert, search and delete over the bucket chains, comparing
// stored keys one character at a time.
// ----------------------------------------------------------------------------
module chkv_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_kb_we,
    input  logic [chkv_pkg::CountW-1:0]   i_kb_addr,
    input  logic [7:0]                    i_kb_data,
    input  logic                          i_cmd_valid,
    input  chkv_pkg::t_cmd                i_cmd,
    output logic                          o_cmd_pop,
    output logic                          o_idle,
    output logic                          o_strobe,
    output logic [1:0]                    o_status,
    output logic signed [31:0]            o_value_out
);
    import chkv_pkg::*;

    t_state r_state, n_state;
    t_cmd   r_cmd;
    logic [EntryW-1:0]      r_head [Buckets];
    logic [PoolEntries-1:0] r_free;
    logic [EntryW-1:0]      r_cur, r_prev, r_nxt, r_alloc;
    logic [CountW-1:0]      r_idx;
    logic [6:0]             r_steps;
    logic [CountW-1:0]      r_len;

    // key buffer (live key)
    logic [7:0]        kb_rd;
    logic [CountW-1:0] kb_raddr;
    chkv_ram #(.Width(8), .Depth(KeyChars)) u_kbuf (
        .i_clk, .i_we(i_kb_we), .i_waddr(i_kb_addr[$clog2(KeyChars)-1:0]),
        .i_wdata(i_kb_data), .i_raddr(kb_raddr[$clog2(KeyChars)-1:0]),
        .o_rdata(kb_rd));

    // stored keys
    logic              ek_we;
    logic [KeyMemW-1:0] ek_waddr, ek_raddr;
    logic [7:0]        ek_rd;
    chkv_ram #(.Width(8), .Depth(KeyMemD)) u_ekey (
        .i_clk, .i_we(ek_we), .i_waddr(ek_waddr), .i_wdata(kb_rd),
        .i_raddr(ek_raddr), .o_rdata(ek_rd));

    // per-entry next, length, value
    logic                    en_we;
    logic [EntryW-1:0]       en_waddr, en_wdata, en_rd;
    logic [$clog2(PoolEntries)-1:0] ent_ra;
    chkv_ram #(.Width(EntryW), .Depth(PoolEntries)) u_next (
        .i_clk, .i_we(en_we), .i_waddr(en_waddr[$clog2(PoolEntries)-1:0]),
        .i_wdata(en_wdata), .i_raddr(ent_ra), .o_rdata(en_rd));

    logic              ins_we;
    logic [CountW-1:0] el_rd;
    chkv_ram #(.Width(CountW), .Depth(PoolEntries)) u_len (
        .i_clk, .i_we(ins_we), .i_waddr(r_alloc[$clog2(PoolEntries)-1:0]),
        .i_wdata(r_cmd.count), .i_raddr(ent_ra), .o_rdata(el_rd));

    logic [31:0] ev_rd;
    chkv_ram #(.Width(32), .Depth(PoolEntries)) u_val (
        .i_clk, .i_we(ins_we), .i_waddr(r_alloc[$clog2(PoolEntries)-1:0]),
        .i_wdata(r_cmd.value), .i_raddr(ent_ra), .o_rdata(ev_rd));

    assign ent_ra = r_cur[$clog2(PoolEntries)-1:0];

    // lowest free entry
    logic [EntryW-1:0] low_free;
    always_comb begin
        low_free = NullLink;
        for (int i = PoolEntries - 1; i >= 0; i--) begin
            if (r_free[i]) begin
                low_free = EntryW'(i);
            end
        end
    end

    logic [KeyMemW-1:0] ent_base_cur, ent_base_alloc;
    assign ent_base_cur   = KeyMemW'(r_cur * KeyChars);
    assign ent_base_alloc = KeyMemW'(r_alloc * KeyChars);

    // chars_done marks the last character of the key under compare
    logic is_ins, chars_done;
    assign is_ins     = (r_cmd.action == ACT_INSERT);
    assign chars_done = (CountW'(r_idx + 1'b1) == r_len);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:    if (i_cmd_valid) n_state = S_CLEAR;
            S_CLEAR: begin
                if (r_cmd.overflow) n_state = S_DONE;
                else if (is_ins) n_state = (low_free == NullLink) ? S_DONE : S_INS_KEY;
                else n_state = S_HEAD;
            end
            S_INS_KEY: if (r_idx == r_cmd.count) n_state = S_INS_FIN;
            S_INS_FIN: n_state = S_DONE;
            S_HEAD:    n_state = (r_cur == NullLink ||
                                  r_cur >= EntryW'(PoolEntries)) ? S_DONE : S_ENTRY;
            S_ENTRY:   n_state = S_ENTRY_W;
            // an empty key matches on length alone
            S_ENTRY_W: n_state = (el_rd != r_cmd.count) ? S_NEXT :
                                 (r_cmd.count == '0) ? S_HIT : S_CMP;
            S_CMP:     n_state = S_CMP_W;
            S_CMP_W: begin
                if (ek_rd != kb_rd) n_state = S_NEXT;
                else if (chars_done) n_state = S_HIT;
                else n_state = S_CMP;
            end
            S_NEXT:    n_state = (r_nxt >= EntryW'(PoolEntries) ||
                                  r_steps == 7'(PoolEntries)) ? S_DONE : S_ENTRY;
            S_HIT:     n_state = S_DONE;
            S_DONE:    n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    // memory control
    always_comb begin
        kb_raddr = r_idx;
        ek_raddr = ent_base_cur + KeyMemW'(r_idx);
        ek_we    = (r_state == S_INS_KEY) && (r_idx != '0);
        ek_waddr = ent_base_alloc + KeyMemW'(r_idx - 1'b1);
        ins_we   = (r_state == S_INS_FIN);
        en_we    = ins_we || (r_state == S_HIT && r_cmd.action == ACT_DELETE &&
                              r_prev != NullLink);
        en_waddr = ins_we ? r_alloc : r_prev;
        en_wdata = ins_we ? r_head[r_cmd.bucket] : r_nxt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_free   <= '1;
            o_strobe <= 1'b0;
            for (int b = 0; b < Buckets; b++) r_head[b] <= NullLink;
        end else begin
            r_state  <= n_state;
            o_strobe <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    r_cmd <= i_cmd;
                    r_idx <= '0;
                end
                S_CLEAR: begin
                    r_alloc     <= low_free;
                    r_cur       <= r_head[r_cmd.bucket];
                    r_prev      <= NullLink;
                    r_steps     <= '0;
                    r_len       <= r_cmd.count;
                    o_status    <= r_cmd.overflow ? ST_TOOLONG :
                                   (is_ins && low_free == NullLink) ? ST_FULL : ST_OK;
                    o_value_out <= MissValue;
                end
                S_INS_KEY: r_idx <= r_idx + 1'b1;
                S_INS_FIN: begin
                    r_head[r_cmd.bucket] <= r_alloc;
                    r_free[r_alloc[$clog2(PoolEntries)-1:0]] <= 1'b0;
                end
                S_HEAD: if (n_state == S_DONE) o_status <= ST_NOTFOUND;
                S_ENTRY: r_idx <= '0;
                S_ENTRY_W: r_nxt <= en_rd;
                S_CMP: ;
                S_CMP_W: r_idx <= r_idx + 1'b1;
                S_NEXT: begin
                    r_prev  <= r_cur;
                    r_cur   <= r_nxt;
                    r_steps <= r_steps + 1'b1;
                    r_idx   <= '0;
                    if (n_state == S_DONE) o_status <= ST_NOTFOUND;
                end
                S_HIT: begin
                    if (r_cmd.action == ACT_DELETE) begin
                        if (r_prev == NullLink) r_head[r_cmd.bucket] <= r_nxt;
                        r_free[ent_ra] <= 1'b1;
                    end else begin
                        o_value_out <= ev_rd;
                    end
                end
                S_DONE: o_strobe <= 1'b1;
                default: ;
            endcase
        end
    end

    assign o_cmd_pop = (r_state == S_IDLE) && i_cmd_valid;
    assign o_idle    = (r_state == S_IDLE) && !i_cmd_valid;
endmodule

@@ rtl/chained_hash_key_value_store_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chained_hash_key_value_store_top
// Key-value store with separately chained hash buckets.
// ----------------------------------------------------------------------------
// Usage: drive i_action, i_key_char and i_value_in with start high; a beat
// is taken at an edge where busy is low. Nonzero characters build the key.
// A zero character ends the key and runs the action; one result beat
// appears on o_status / o_value_out with o_result_valid high for one cycle.
// The receiver cannot stall and results are never held.
// The bucket chain walk in the back end sets the rate; the next key waits
// (busy) until the previous terminator is finished.
// Reset (i_rst_n low, synchronous) empties every bucket and frees the pool;
// no clearing pass is needed.
// ----------------------------------------------------------------------------
module chained_hash_key_value_store_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_action,
    input  logic [7:0]         i_key_char,
    input  logic signed [31:0] i_value_in,
    output logic               o_result_valid,
    output logic [1:0]         o_status,
    output logic signed [31:0] o_value_out
);
    import chkv_pkg::*;

    logic              kb_we, cmd_valid, cmd_pop, back_idle;
    logic [CountW-1:0] kb_addr;
    logic [7:0]        kb_data;
    t_cmd              cmd;

    chkv_front u_front (
        .i_clk, .i_rst_n, .i_start(start), .o_busy(busy),
        .i_action, .i_key_char, .i_value_in,
        .o_kb_we(kb_we), .o_kb_addr(kb_addr), .o_kb_data(kb_data),
        .o_cmd_valid(cmd_valid), .o_cmd(cmd), .i_cmd_pop(cmd_pop),
        .i_back_idle(back_idle));

    chkv_back u_back (
        .i_clk, .i_rst_n, .i_kb_we(kb_we), .i_kb_addr(kb_addr),
        .i_kb_data(kb_data), .i_cmd_valid(cmd_valid), .i_cmd(cmd),
        .o_cmd_pop(cmd_pop), .o_idle(back_idle), .o_strobe(o_result_valid),
        .o_status, .o_value_out);
endmodule
